@@ rtl/assert_macros.svh @@
// Assertion macros shared by the route lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/rld_pkg.sv @@
// Shared constants, types and helpers for the route lookup block.
package rld_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int PORT_COUNT    = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAX_METRIC    = 15;

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_FORWARD = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_TTL     = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [4:0]  hops;
    logic [2:0]  port;
  } route_ent_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  hops;
    logic [31:0] gateway;
    logic [2:0]  port;
  } scan_res_t;

  function automatic logic port_ok(input logic [2:0] p);
    return 32'(p) < PORT_COUNT;
  endfunction

endpackage

@@ rtl/rld_route_ram.sv @@
// Single write port, single registered read port route table memory.
module rld_route_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/rld_scan_unit.sv @@
// Longest-prefix match walker: reads every slot once and keeps the best hit.
`include "assert_macros.svh"

module rld_scan_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [31:0]                    key,
  input  logic [rld_pkg::TABLE_ENTRIES-1:0] live,
  output logic                           rd_en,
  output logic [rld_pkg::IDX_W-1:0]      rd_addr,
  input  rld_pkg::route_ent_t            rd_data,
  output logic                           done,
  output rld_pkg::scan_res_t             res
);

  import rld_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic             issuing_r, issuing_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             cmp_v_r;
  logic             cmp_last_r;
  logic             cmp_live_r;
  logic             done_r;
  logic [31:0]      key_r;
  logic             found_r, found_nxt;
  logic [31:0]      best_mask_r;
  logic [4:0]       best_hops_r;
  logic [31:0]      best_gw_r;
  logic [2:0]       best_port_r;
  logic             hit;

  always_comb begin
    issuing_nxt = issuing_r;
    idx_nxt     = idx_r;
    if (start) begin
      issuing_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (issuing_r) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == LAST_IDX) begin
        issuing_nxt = 1'b0;
      end
    end
  end

  // Later slot wins on equal masks, hence >=.
  assign hit = cmp_v_r && cmp_live_r &&
               (((rd_data.prefix ^ key_r) & rd_data.mask) == 32'd0) &&
               (!found_r || (rd_data.mask >= best_mask_r));

  assign found_nxt = start ? 1'b0 : (found_r | hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      cmp_v_r   <= 1'b0;
      done_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      issuing_r <= issuing_nxt;
      cmp_v_r   <= issuing_r;
      done_r    <= cmp_v_r && cmp_last_r;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_last_r <= (idx_r == LAST_IDX);
    cmp_live_r <= live[idx_r];
    if (start) begin
      key_r <= key;
    end
    if (hit) begin
      best_mask_r <= rd_data.mask;
      best_hops_r <= rd_data.hops;
      best_gw_r   <= rd_data.gateway;
      best_port_r <= rd_data.port;
    end
  end

  assign rd_en       = issuing_r;
  assign rd_addr     = idx_r;
  assign done        = done_r;
  assign res.found   = found_r;
  assign res.hops    = best_hops_r;
  assign res.gateway = best_gw_r;
  assign res.port    = best_port_r;

  `ASSERT_CLK(a_done_pulse, done_r |=> !done_r, "scan done held for more than one cycle")
  `ASSERT_NEVER(a_start_while_issuing, start && issuing_r, "scan restarted mid walk")
  `ASSERT_NEVER(a_start_while_cmp, start && cmp_v_r, "scan restarted during compare")

endmodule

@@ rtl/route_lookup_forward_decision_core.sv @@
// Top level: route table, lookup sequencer and result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, entry_*, dest_address, ttl
//  out_    | output    | out_valid/out_stall| status, out_port, next_hop, new_ttl, metric
//
// A write transaction is accepted and its result is registered at once.
// A lookup walks all TABLE_ENTRIES slots through the one read port of the table
// RAM; a second walk, keyed on the gateway, follows for gateway routes.
// Reset synchronously clears the live bits held in flip-flops; table contents are not cleared.
// in_stall is high while a lookup runs and while an unaccepted result is stalled.
`include "assert_macros.svh"

module route_lookup_forward_decision_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [4:0]  in_entry_index,
  input  logic        in_entry_valid,
  input  logic [31:0] in_entry_prefix,
  input  logic [31:0] in_entry_mask,
  input  logic [31:0] in_entry_gateway,
  input  logic [4:0]  in_entry_metric,
  input  logic [2:0]  in_entry_port,
  input  logic [31:0] in_dest_address,
  input  logic [7:0]  in_ttl,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_out_port,
  output logic [31:0] out_next_hop,
  output logic [7:0]  out_new_ttl,
  output logic [4:0]  out_route_metric
);

  import rld_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1;
  localparam logic [1:0] S_SCAN2 = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] live_r;
  logic                    in_acc, is_wr, wr_en, out_free;
  logic [IDX_W-1:0]        wr_addr;
  route_ent_t              wr_ent, rd_ent;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    scan_start, scan_done, scan2_go;
  logic [31:0]             scan_key;
  scan_res_t               res;

  logic [31:0] dest_r;
  logic [7:0]  ttl_r;
  logic [31:0] gw_r, gw_nxt;
  logic [1:0]  pst_r, pst_nxt;
  logic [2:0]  pport_r, pport_nxt;
  logic [31:0] phop_r, phop_nxt;
  logic [7:0]  pttl_r, pttl_nxt;
  logic [4:0]  pmetric_r, pmetric_nxt;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [2:0]  out_port_r;
  logic [31:0] out_hop_r;
  logic [7:0]  out_ttl_r;
  logic [4:0]  out_metric_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_wr    = (in_command == CMD_WRITE);
  assign wr_en    = in_acc && is_wr && (32'(in_entry_index) < TABLE_ENTRIES);
  assign wr_addr  = IDX_W'(in_entry_index);

  assign wr_ent.prefix  = in_entry_prefix;
  assign wr_ent.mask    = in_entry_mask;
  assign wr_ent.gateway = in_entry_gateway;
  assign wr_ent.hops    = in_entry_metric;
  assign wr_ent.port    = in_entry_port;

  rld_route_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH ($bits(route_ent_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_ent)
  );

  rld_scan_unit u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .key     (scan_key),
    .live    (live_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_ent),
    .done    (scan_done),
    .res     (res)
  );

  assign scan_key   = (state_r == S_IDLE) ? in_dest_address : res.gateway;
  assign scan_start = (in_acc && !is_wr) || scan2_go;

  always_comb begin
    state_nxt   = state_r;
    gw_nxt      = gw_r;
    pst_nxt     = pst_r;
    pport_nxt   = pport_r;
    phop_nxt    = phop_r;
    pttl_nxt    = pttl_r;
    pmetric_nxt = pmetric_r;
    scan2_go    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !is_wr) begin
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (scan_done) begin
          pmetric_nxt = res.found ? res.hops : 5'd0;
          gw_nxt      = res.gateway;
          pport_nxt   = 3'd0;
          phop_nxt    = 32'd0;
          pttl_nxt    = 8'd0;
          pst_nxt     = ST_UNREACH;
          state_nxt   = S_OUT;
          priority if (!res.found || (res.hops > 5'(MAX_METRIC))) begin
            pst_nxt = ST_UNREACH;
          end else if (ttl_r <= 8'd1) begin
            pst_nxt = ST_TTL;
          end else if (res.hops == 5'd0) begin
            if (port_ok(res.port)) begin
              pst_nxt   = ST_FORWARD;
              pport_nxt = res.port;
              phop_nxt  = dest_r;
              pttl_nxt  = ttl_r - 8'd1;
            end
          end else begin
            scan2_go  = 1'b1;
            state_nxt = S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        if (scan_done) begin
          state_nxt = S_OUT;
          if (res.found && port_ok(res.port)) begin
            pst_nxt   = ST_FORWARD;
            pport_nxt = res.port;
            phop_nxt  = gw_r;
            pttl_nxt  = ttl_r - 8'd1;
          end else begin
            pst_nxt = ST_UNREACH;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        live_r[wr_addr] <= in_entry_valid;
      end
      if ((in_acc && is_wr) || (state_r == S_OUT && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_wr) begin
      dest_r <= in_dest_address;
      ttl_r  <= in_ttl;
    end
    gw_r      <= gw_nxt;
    pst_r     <= pst_nxt;
    pport_r   <= pport_nxt;
    phop_r    <= phop_nxt;
    pttl_r    <= pttl_nxt;
    pmetric_r <= pmetric_nxt;
    if (in_acc && is_wr) begin
      out_status_r <= ST_WRITTEN;
      out_port_r   <= 3'd0;
      out_hop_r    <= 32'd0;
      out_ttl_r    <= 8'd0;
      out_metric_r <= 5'd0;
    end else if (state_r == S_OUT && out_free) begin
      out_status_r <= pst_r;
      out_port_r   <= pport_r;
      out_hop_r    <= phop_r;
      out_ttl_r    <= pttl_r;
      out_metric_r <= pmetric_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_out_port     = out_port_r;
  assign out_next_hop     = out_hop_r;
  assign out_new_ttl      = out_ttl_r;
  assign out_route_metric = out_metric_r;

  `ASSERT_CLK(a_done_in_scan, scan_done |-> (state_r == S_SCAN1 || state_r == S_SCAN2), "scan done outside a walk")
  `ASSERT_CLK(a_fwd_ttl, (out_valid_r && out_status_r == ST_FORWARD) |-> (out_ttl_r != 8'd0), "forwarded with zero TTL")
  `ASSERT_NEVER(a_wr_during_scan, wr_en && (state_r != S_IDLE), "table written during a lookup")

endmodule
